// ===== design/adaptive_fifo_linear_resampler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive FIFO linear resampler
// Implication checks, with and without a delay to the next cycle.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_FIFO_LINEAR_RESAMPLER_MACROS_SVH
`define ADAPTIVE_FIFO_LINEAR_RESAMPLER_MACROS_SVH

// same-cycle implication
`define AFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg
// Shared types, constants and register codes of the resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

   localparam int SAMPLE_BITS        = 24;
   localparam int FILL_BITS          = 14;
   localparam int UNDER_BITS         = 16;
   localparam int RATIO_BITS         = 28;
   localparam int DEV_BITS           = 16;
   localparam int PHASE_BITS         = 32;
   localparam int FRAC_BITS          = 24;
   localparam int CSR_IDX_BITS       = 2;
   localparam int CSR_DATA_BITS      = 28;
   localparam int DEFAULT_RING_DEPTH = 8192;

   localparam logic [PHASE_BITS-1:0] PHASE_ONE = 32'h0100_0000;

   localparam logic [RATIO_BITS-1:0] BASE_RATIO_RESET  = 28'd16777216;
   localparam logic [FILL_BITS-1:0]  TARGET_FILL_RESET = 14'd2048;
   localparam logic [DEV_BITS-1:0]   MAX_DEV_RESET     = 16'd328;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ENABLE        = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_RATIO    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TARGET_FILL   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_DEVIATION = 2'd3;

   localparam logic OP_PUSH = 1'b0;

   typedef struct packed {
      logic                          operation;
      logic signed [SAMPLE_BITS-1:0] in_left;
      logic signed [SAMPLE_BITS-1:0] in_right;
      logic                          block_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
      logic [FILL_BITS-1:0]          fill_level;
      logic [UNDER_BITS-1:0]         underrun_count;
      logic                          is_primed;
   } rsp_type;

   typedef struct packed {
      logic                  enable;
      logic [RATIO_BITS-1:0] base_ratio;
      logic [FILL_BITS-1:0]  target_fill;
      logic [DEV_BITS-1:0]   max_deviation;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_PUSH       = 3'b001,
      CMD_PULL       = 3'b010,
      CMD_PULL_START = 3'b100
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
   } cmd_type;

   typedef struct packed {
      logic primed;
      logic silenced;
      logic wait_ratio;
   } back_stat_type;

endpackage

`default_nettype wire

// ===== design/afr_ram.sv =====
// ----------------------------------------------------------------------------
// afr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/afr_front.sv =====
// ----------------------------------------------------------------------------
// afr_front
// Input queue: accept request words, classify them, hold two for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire afr_pkg::req_type req_data,
   output logic                  cmd_valid,
   output afr_pkg::cmd_type      cmd,
   input  wire logic             cmd_take
);

   import afr_pkg::*;

   function automatic cmd_type classify(input req_type r);
      cmd_type c;
      if (r.operation == OP_PUSH) begin
         c.kind = CMD_PUSH;
      end else if (r.block_start) begin
         c.kind = CMD_PULL_START;
      end else begin
         c.kind = CMD_PULL;
      end
      c.left  = r.in_left;
      c.right = r.in_right;
      return c;
   endfunction

   cmd_type     slot0_ff, slot0_in;
   cmd_type     slot1_ff, slot1_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     incoming;
   logic        push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot0_ff;
   assign incoming  = classify(req_data);
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_take && cmd_valid;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = incoming;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = incoming;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = incoming;
         end else begin
            slot1_in = incoming;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// ===== design/afr_ratio.sv =====
// ----------------------------------------------------------------------------
// afr_ratio
// Ratio update: bit-serial fill-error division, then staged multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_ratio #(
   parameter int FC_W = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire afr_pkg::cfg_type cfg,
   input  wire logic             start,
   input  wire logic [FC_W-1:0]  frame_count,
   output logic                  done,
   output logic [afr_pkg::PHASE_BITS-1:0] ratio
);

   import afr_pkg::*;

   localparam int DW = ((FC_W > FILL_BITS) ? FC_W : FILL_BITS) + 1;

   typedef enum logic [6:0] {
      R_IDLE = 7'b0000001,
      R_DIV  = 7'b0000010,
      R_MUL0 = 7'b0000100,
      R_MUL1 = 7'b0001000,
      R_MUL2 = 7'b0010000,
      R_SUM1 = 7'b0100000,
      R_SUM2 = 7'b1000000
   } rstate_type;

   rstate_type              state_ff, state_in;
   logic                    neg_ff, neg_in;
   logic [FILL_BITS:0]      rem_ff, rem_in;
   logic [16:0]             quo_ff, quo_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [31:0]             corr_ff, corr_in;
   logic [43:0]             plo_ff, plo_in;
   logic [43:0]             phi_ff, phi_in;
   logic [59:0]             prod_ff, prod_in;
   logic                    done_ff, done_in;
   logic [PHASE_BITS-1:0]   ratio_ff, ratio_in;

   logic [DW-1:0]           diff, mag;
   logic [FILL_BITS-1:0]    den;
   logic [FILL_BITS:0]      rem_sh;
   logic [61:0]             full, total;

   assign done  = done_ff;
   assign ratio = ratio_ff;

   always_comb begin
      diff   = DW'(frame_count) - DW'(cfg.target_fill);
      mag    = diff[DW-1] ? (~diff + 1'b1) : diff;
      den    = (cfg.target_fill == '0) ? FILL_BITS'(1) : cfg.target_fill;
      rem_sh = {rem_ff[FILL_BITS-1:0], 1'b0};
      full   = {2'b00, cfg.base_ratio, 32'h0000_0000};
      total  = (neg_ff ? (full - 62'(prod_ff)) : (full + 62'(prod_ff)))
               + 62'h0_8000_0000;

      state_in = state_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      corr_in  = corr_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      ratio_in = ratio_ff;

      case (state_ff)
         R_IDLE: begin
            if (start) begin
               neg_in = diff[DW-1];
               cnt_in = 4'd0;
               if (mag >= DW'(den)) begin
                  // error saturates at one
                  quo_in   = 17'h1_0000;
                  state_in = R_MUL0;
               end else begin
                  quo_in   = 17'd0;
                  rem_in   = (FILL_BITS+1)'(mag);
                  state_in = R_DIV;
               end
            end
         end
         R_DIV: begin
            // one quotient bit a cycle
            if (rem_sh >= {1'b0, den}) begin
               rem_in = rem_sh - {1'b0, den};
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[15:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = R_MUL0;
            end
         end
         R_MUL0: begin
            corr_in  = 32'(cfg.max_deviation) * 32'(quo_ff);
            state_in = R_MUL1;
         end
         R_MUL1: begin
            plo_in   = cfg.base_ratio * corr_ff[15:0];
            state_in = R_MUL2;
         end
         R_MUL2: begin
            phi_in   = cfg.base_ratio * corr_ff[31:16];
            state_in = R_SUM1;
         end
         R_SUM1: begin
            prod_in  = {phi_ff, 16'h0000} + 60'(plo_ff);
            state_in = R_SUM2;
         end
         R_SUM2: begin
            ratio_in = 32'(total[61:32]);
            done_in  = 1'b1;
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      corr_ff  <= corr_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      prod_ff  <= prod_in;
      ratio_ff <= ratio_in;
   end

endmodule

`default_nettype wire

// ===== design/afr_back.sv =====
// ----------------------------------------------------------------------------
// afr_back
// Execution sequencer: ring store, priming, phase stepping and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_back #(
   parameter int RING_DEPTH = 8192,
   parameter int FC_W       = 14
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire afr_pkg::cfg_type cfg,
   input  wire logic             run_clear,
   input  wire logic             cmd_valid,
   input  wire afr_pkg::cmd_type cmd,
   output logic                  cmd_take,
   output logic                  ratio_start,
   input  wire logic             ratio_done,
   input  wire logic [afr_pkg::PHASE_BITS-1:0] ratio_value,
   output logic [FC_W-1:0]       frame_count,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output afr_pkg::rsp_type      rsp_data,
   output afr_pkg::back_stat_type stat
);

   import afr_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CW    = (FC_W > FILL_BITS) ? FC_W : FILL_BITS;
   localparam int SB    = SAMPLE_BITS;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PRIME  = 9'b000000010,
      ST_RSTART = 9'b000000100,
      ST_RATIO  = 9'b000001000,
      ST_LOOP   = 9'b000010000,
      ST_POPW   = 9'b000100000,
      ST_MUL    = 9'b001000000,
      ST_SUM    = 9'b010000000,
      ST_DONE   = 9'b100000000
   } bstate_type;

   bstate_type               state_ff, state_in;
   logic [PTR_W-1:0]         rp_ff, rp_in, wp_ff, wp_in;
   logic [FC_W-1:0]          fc_ff, fc_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in, ratio_ff, ratio_in;
   logic signed [SB-1:0]     prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SB-1:0]     cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic signed [SB-1:0]     out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic signed [2*SB+1:0]   prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic                     primed_ff, primed_in, silenced_ff, silenced_in;
   logic [UNDER_BITS-1:0]    under_ff, under_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     ram_we, ram_re;
   logic [2*SB-1:0]          ram_rd;
   logic [FILL_BITS-1:0]     need;
   logic signed [SB:0]       d_l, d_r, t_ext;
   logic signed [2*SB+1:0]   rnd_l, rnd_r;
   logic [PTR_W-1:0]         rp_next, wp_next;

   afr_ram #(
      .WIDTH (2*SB),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data ({cmd.left, cmd.right}),
      .rd_en   (ram_re),
      .rd_addr (rp_ff),
      .rd_data (ram_rd)
   );

   assign frame_count     = fc_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign stat.primed     = primed_ff;
   assign stat.silenced   = silenced_ff;
   assign stat.wait_ratio = (state_ff == ST_RATIO);
   assign ratio_start     = (state_ff == ST_RSTART);

   always_comb begin
      need    = (cfg.target_fill == '0) ? FILL_BITS'(1) : cfg.target_fill;
      rp_next = (rp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      wp_next = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      d_l     = {cur_l_ff[SB-1], cur_l_ff} - {prev_l_ff[SB-1], prev_l_ff};
      d_r     = {cur_r_ff[SB-1], cur_r_ff} - {prev_r_ff[SB-1], prev_r_ff};
      t_ext   = {1'b0, phase_ff[FRAC_BITS-1:0]};
      rnd_l   = prod_l_ff + (2*SB+2)'(PHASE_ONE >> 1);
      rnd_r   = prod_r_ff + (2*SB+2)'(PHASE_ONE >> 1);

      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fc_in        = fc_ff;
      phase_in     = phase_ff;
      ratio_in     = ratio_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      primed_in    = primed_ff;
      silenced_in  = silenced_ff;
      under_in     = under_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd_take     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               out_l_in = '0;
               out_r_in = '0;
               state_in = ST_DONE;
               case (cmd.kind)
                  CMD_PUSH: begin
                     if (cfg.enable && (fc_ff < FC_W'(RING_DEPTH))) begin
                        ram_we = 1'b1;
                        wp_in  = wp_next;
                        fc_in  = fc_ff + 1'b1;
                     end
                  end
                  CMD_PULL_START: begin
                     if (cfg.enable && (cfg.base_ratio != '0)) begin
                        silenced_in = 1'b0;
                        if (primed_ff) begin
                           state_in = ST_RSTART;
                        end else if (CW'(fc_ff) < CW'(need)) begin
                           silenced_in = 1'b1;
                        end else begin
                           primed_in = 1'b1;
                           phase_in  = '0;
                           ram_re    = 1'b1;
                           rp_in     = rp_next;
                           fc_in     = fc_ff - 1'b1;
                           state_in  = ST_PRIME;
                        end
                     end
                  end
                  CMD_PULL: begin
                     if (cfg.enable && (cfg.base_ratio != '0) && primed_ff
                         && !silenced_ff) begin
                        state_in = ST_LOOP;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PRIME: begin
            cur_l_in  = ram_rd[2*SB-1:SB];
            cur_r_in  = ram_rd[SB-1:0];
            prev_l_in = ram_rd[2*SB-1:SB];
            prev_r_in = ram_rd[SB-1:0];
            state_in  = ST_RSTART;
         end
         ST_RSTART: begin
            state_in = ST_RATIO;
         end
         ST_RATIO: begin
            if (ratio_done) begin
               ratio_in = ratio_value;
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (phase_ff[PHASE_BITS-1:FRAC_BITS] != '0) begin
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               if (fc_ff == '0) begin
                  if (under_ff != '1) begin
                     under_in = under_ff + 1'b1;
                  end
                  primed_in   = 1'b0;
                  silenced_in = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  ram_re   = 1'b1;
                  rp_in    = rp_next;
                  fc_in    = fc_ff - 1'b1;
                  phase_in = phase_ff - PHASE_ONE;
                  state_in = ST_POPW;
               end
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_POPW: begin
            cur_l_in = ram_rd[2*SB-1:SB];
            cur_r_in = ram_rd[SB-1:0];
            state_in = ST_LOOP;
         end
         ST_MUL: begin
            prod_l_in = d_l * t_ext;
            prod_r_in = d_r * t_ext;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            out_l_in = prev_l_ff + rnd_l[FRAC_BITS+SB-1:FRAC_BITS];
            out_r_in = prev_r_ff + rnd_r[FRAC_BITS+SB-1:FRAC_BITS];
            phase_in = phase_ff + ratio_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand the word over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.out_left       = out_l_ff;
               rsp_data_in.out_right      = out_r_ff;
               rsp_data_in.fill_level     = FILL_BITS'(fc_ff);
               rsp_data_in.underrun_count = under_ff;
               rsp_data_in.is_primed      = primed_ff;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (run_clear) begin
         rp_in       = '0;
         wp_in       = '0;
         fc_in       = '0;
         phase_in    = '0;
         ratio_in    = '0;
         prev_l_in   = '0;
         prev_r_in   = '0;
         cur_l_in    = '0;
         cur_r_in    = '0;
         primed_in   = 1'b0;
         silenced_in = 1'b0;
         under_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fc_ff        <= '0;
         phase_ff     <= '0;
         ratio_ff     <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         cur_l_ff     <= '0;
         cur_r_ff     <= '0;
         primed_ff    <= 1'b0;
         silenced_ff  <= 1'b0;
         under_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fc_ff        <= fc_in;
         phase_ff     <= phase_in;
         ratio_ff     <= ratio_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         cur_l_ff     <= cur_l_in;
         cur_r_ff     <= cur_r_in;
         primed_ff    <= primed_in;
         silenced_ff  <= silenced_in;
         under_ff     <= under_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_l_ff    <= out_l_in;
      out_r_ff    <= out_r_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/adaptive_fifo_linear_resampler.sv =====
// ----------------------------------------------------------------------------
// adaptive_fifo_linear_resampler
// Stereo frame ring with adaptive-ratio linear interpolation on pull.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item: a push (store a source frame) or a pull
//   (produce one output frame, block_start marking the first of a block).
//   rsp_* returns exactly one word per item, in order. csr_* writes the
//   enable, base ratio, target fill and maximum deviation registers; write
//   them only while the block is idle. Writing enable from 0 to 1 clears the
//   ring pointers, phase, priming and underrun counter.
// Sequencing (one item at a time in the back end):
//   a push stores one frame in the ring when enabled and not full; a pull
//   pops frames from the ring RAM as its phase needs, then interpolates.
//   A block-start pull that primes or finds the ring primed first runs the
//   ratio update: the bit-serial fill-error divider (16 steps), skipped
//   when the fill error saturates, then the staged ratio multiplies.
// Reset and stall:
//   reset empties the input queue and clears all run state; the registers
//   return to their defaults. A two-word queue lets pushes and pulls be
//   accepted while the back end works; a stalled result is held in the
//   output register while the next item is already being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_fifo_linear_resampler_macros.svh"

module adaptive_fifo_linear_resampler #(
   parameter int RING_DEPTH = afr_pkg::DEFAULT_RING_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire afr_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output afr_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_write,
   input  wire logic [afr_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [afr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   import afr_pkg::*;

   localparam int FC_W = $clog2(RING_DEPTH + 1);

   // configuration registers
   logic                  enable_ff, enable_in;
   logic [RATIO_BITS-1:0] base_ff, base_in;
   logic [FILL_BITS-1:0]  target_ff, target_in;
   logic [DEV_BITS-1:0]   dev_ff, dev_in;
   cfg_type               cfg;
   logic                  run_clear;

   // front to back queue
   logic                  cmd_valid, cmd_take;
   cmd_type               cmd;

   // ratio unit handshake
   logic                  ratio_start, ratio_done;
   logic [PHASE_BITS-1:0] ratio_value;
   logic [FC_W-1:0]       frame_count;
   back_stat_type         back_stat;

   assign cfg.enable        = enable_ff;
   assign cfg.base_ratio    = base_ff;
   assign cfg.target_fill   = target_ff;
   assign cfg.max_deviation = dev_ff;

   // a rising enable restarts the run
   assign run_clear = csr_write && (csr_index == CSR_ENABLE) && csr_wdata[0] && !enable_ff;

   always_comb begin
      enable_in = enable_ff;
      base_in   = base_ff;
      target_in = target_ff;
      dev_in    = dev_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ENABLE:        enable_in = csr_wdata[0];
            CSR_BASE_RATIO:    base_in   = csr_wdata[RATIO_BITS-1:0];
            CSR_TARGET_FILL:   target_in = csr_wdata[FILL_BITS-1:0];
            CSR_MAX_DEVIATION: dev_in    = csr_wdata[DEV_BITS-1:0];
            default:           enable_in = enable_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         base_ff   <= BASE_RATIO_RESET;
         target_ff <= TARGET_FILL_RESET;
         dev_ff    <= MAX_DEV_RESET;
      end else begin
         enable_ff <= enable_in;
         base_ff   <= base_in;
         target_ff <= target_in;
         dev_ff    <= dev_in;
      end
   end

   afr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   afr_ratio #(
      .FC_W (FC_W)
   ) u_ratio (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .start       (ratio_start),
      .frame_count (frame_count),
      .done        (ratio_done),
      .ratio       (ratio_value)
   );

   afr_back #(
      .RING_DEPTH (RING_DEPTH),
      .FC_W       (FC_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .run_clear   (run_clear),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take),
      .ratio_start (ratio_start),
      .ratio_done  (ratio_done),
      .ratio_value (ratio_value),
      .frame_count (frame_count),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .stat        (back_stat)
   );

   // the ratio unit only finishes while the back end waits for it
   `AFR_ASSERT_IMPL(a_ratio_done_waited, clock, reset, ratio_done, back_stat.wait_ratio, "ratio result with no waiter")

   // a restarted run is never primed
   `AFR_ASSERT_NEXT(a_clear_unprimed, clock, reset, run_clear, !back_stat.primed, "primed after run clear")

   // output drawn from the ring only while primed
   `AFR_ASSERT_IMPL(a_silent_unprimed, clock, reset, rsp_valid && !rsp_data.is_primed, (rsp_data.out_left == '0) && (rsp_data.out_right == '0), "sound while unprimed")

endmodule

`default_nettype wire
